// ----- design/csirp_pkg.sv -----
// csirp_pkg: shared constants and types for the CSI report parser.
// Holds byte codes, report kinds, default parameter values and the step struct.
// No dependencies.
`timescale 1ns / 1ps

package csirp_pkg;

   // Default sizing of the argument store
   localparam int ARG_SLOTS_DEF = 5;
   localparam int ARG_BITS_DEF  = 16;

   // Result field width (two's complement)
   localparam int OUT_BITS = 17;

   // Byte codes
   localparam logic [7:0] CHR_CSI        = 8'h9B;
   localparam logic [7:0] CHR_ESC        = 8'h1B;
   localparam logic [7:0] CHR_LBRACKET   = 8'h5B;
   localparam logic [7:0] CHR_SEMI       = 8'h3B;
   localparam logic [7:0] CHR_MINUS      = 8'h2D;
   localparam logic [7:0] CHR_SPACE      = 8'h20;
   localparam logic [7:0] CHR_ZERO       = 8'h30;
   localparam logic [7:0] CHR_NINE       = 8'h39;
   localparam logic [7:0] CHR_FINAL_LO   = 8'h40;
   localparam logic [7:0] CHR_FINAL_HI   = 8'h7E;
   localparam logic [7:0] CHR_BOUNDS     = 8'h72;
   localparam logic [7:0] CHR_CURSOR     = 8'h52;
   localparam logic [7:0] CHR_PRINT_LO   = 8'h20;
   localparam logic [7:0] CHR_PRINT_HI   = 8'h7E;
   localparam logic [7:0] CHR_INTER_HI   = 8'h2F;

   // Report kinds (value of the report_kind register)
   localparam logic KIND_CURSOR = 1'b0;
   localparam logic KIND_BOUNDS = 1'b1;

   // Index of the last argument of each report
   localparam int BOUNDS_LAST_ARG = 3;
   localparam int CURSOR_LAST_ARG = 1;

   // Control passed from the parser core to the report formatter
   typedef struct packed {
      logic emit;     // current item completes a matching report
      logic bounds;   // report is a bounds report (else cursor)
   } csirp_step_type;

endpackage

// ----- design/csirp_core.sv -----
// csirp_core: parser state and per-item next-state logic.
// Tracks escape/CSI state, accumulates decimal arguments, detects the final byte.
// Depends on csirp_pkg.
`timescale 1ns / 1ps

module csirp_core #(
   parameter int ARG_SLOTS = csirp_pkg::ARG_SLOTS_DEF,
   parameter int ARG_BITS  = csirp_pkg::ARG_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [7:0]                     rx_byte,
   input  logic                           report_kind,
   output csirp_pkg::csirp_step_type      step,
   output logic signed [ARG_BITS-1:0]     arg_eff [ARG_SLOTS]
);
   import csirp_pkg::*;

   localparam int IDX_BITS = $clog2(ARG_SLOTS);
   localparam int MAG_BITS = ARG_BITS - 1;
   localparam int ACC_BITS = MAG_BITS + 4;

   logic                       in_csi_ff, in_csi_in;
   logic                       in_escape_ff, in_escape_in;
   logic                       in_number_ff, in_number_in;
   logic                       sign_ff, sign_in;
   logic [IDX_BITS-1:0]        arg_index_ff, arg_index_in;
   logic signed [ARG_BITS-1:0] args_ff [ARG_SLOTS];
   logic signed [ARG_BITS-1:0] args_in [ARG_SLOTS];

   logic                is_ctrl, is_digit, is_final, neg_apply, emit;
   logic [MAG_BITS-1:0] base_mag, sat_mag;
   logic [ACC_BITS-1:0] acc;

   // byte classes
   assign is_ctrl  = (rx_byte < CHR_PRINT_LO) || (rx_byte > CHR_PRINT_HI);
   assign is_digit = (rx_byte >= CHR_ZERO) && (rx_byte <= CHR_NINE);
   assign is_final = (rx_byte >= CHR_FINAL_LO) && (rx_byte <= CHR_FINAL_HI);

   // digit accumulate: mag*10 + d, saturated; slot is non-negative while in a number
   always_comb begin
      base_mag = in_number_ff ? args_ff[arg_index_ff][MAG_BITS-1:0] : '0;
      acc = (ACC_BITS'(base_mag) << 3) + (ACC_BITS'(base_mag) << 1)
            + ACC_BITS'(rx_byte[3:0]);
      sat_mag = (acc[ACC_BITS-1:MAG_BITS] != '0) ? {MAG_BITS{1'b1}} : acc[MAG_BITS-1:0];
   end

   // arguments with the pending sign applied to the number being closed
   assign neg_apply = in_number_ff && sign_ff;

   always_comb begin
      for (int i = 0; i < ARG_SLOTS; i++) begin
         if (neg_apply && (arg_index_ff == IDX_BITS'(i)))
            arg_eff[i] = -args_ff[i];
         else
            arg_eff[i] = args_ff[i];
      end
   end

   // report match on the final byte
   assign emit = in_csi_ff && !is_ctrl && !is_digit &&
                 (((rx_byte == CHR_BOUNDS) && (report_kind == KIND_BOUNDS) &&
                   (arg_index_ff == IDX_BITS'(BOUNDS_LAST_ARG))) ||
                  ((rx_byte == CHR_CURSOR) && (report_kind == KIND_CURSOR) &&
                   (arg_index_ff == IDX_BITS'(CURSOR_LAST_ARG))));

   assign step.emit   = emit;
   assign step.bounds = report_kind;

   // next state
   always_comb begin
      in_csi_in    = in_csi_ff;
      in_escape_in = in_escape_ff;
      in_number_in = in_number_ff;
      sign_in      = sign_ff;
      arg_index_in = arg_index_ff;
      args_in      = args_ff;
      if (in_csi_ff) begin
         priority if (is_ctrl) begin
            in_csi_in = 1'b0;
         end else if (is_digit) begin
            in_number_in           = 1'b1;
            args_in[arg_index_ff]  = {1'b0, sat_mag};
         end else begin
            args_in = arg_eff;
            if (in_number_ff) begin
               in_number_in = 1'b0;
               sign_in      = 1'b0;
            end
            priority if (is_final) begin
               in_csi_in = 1'b0;
            end else if (rx_byte == CHR_SEMI) begin
               if (arg_index_ff != IDX_BITS'(ARG_SLOTS - 1))
                  arg_index_in = arg_index_ff + 1'b1;
               sign_in = 1'b0;
            end else if (rx_byte == CHR_MINUS) begin
               if (in_number_ff) begin
                  in_csi_in = 1'b0;
                  sign_in   = 1'b1;
               end else begin
                  sign_in = !sign_ff;
               end
            end else if (rx_byte == CHR_SPACE) begin
               in_csi_in = in_csi_ff;
            end else begin
               in_csi_in = 1'b0;
            end
         end
      end else if (in_escape_ff) begin
         if (rx_byte == CHR_LBRACKET) begin
            in_csi_in    = 1'b1;
            in_escape_in = 1'b0;
            in_number_in = 1'b0;
            sign_in      = 1'b0;
            arg_index_in = '0;
            for (int i = 0; i < ARG_SLOTS; i++) args_in[i] = ARG_BITS'(1);
         end else if (!((rx_byte >= CHR_PRINT_LO) && (rx_byte <= CHR_INTER_HI))) begin
            in_escape_in = 1'b0;
         end
      end else if (rx_byte == CHR_CSI) begin
         in_csi_in    = 1'b1;
         in_escape_in = 1'b0;
         in_number_in = 1'b0;
         sign_in      = 1'b0;
         arg_index_in = '0;
         for (int i = 0; i < ARG_SLOTS; i++) args_in[i] = ARG_BITS'(1);
      end else if (rx_byte == CHR_ESC) begin
         in_escape_in = 1'b1;
      end
   end

   // state registers, updated once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_csi_ff    <= 1'b0;
         in_escape_ff <= 1'b0;
         in_number_ff <= 1'b0;
         sign_ff      <= 1'b0;
         arg_index_ff <= '0;
         for (int i = 0; i < ARG_SLOTS; i++) args_ff[i] <= ARG_BITS'(1);
      end else if (step_en) begin
         in_csi_ff    <= in_csi_in;
         in_escape_ff <= in_escape_in;
         in_number_ff <= in_number_in;
         sign_ff      <= sign_in;
         arg_index_ff <= arg_index_in;
         args_ff      <= args_in;
      end
   end

   // escape and CSI modes exclude each other
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      !(in_csi_ff && in_escape_ff))
      else $error("escape and CSI both active");

   // argument index stays inside the store
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      arg_index_ff <= IDX_BITS'(ARG_SLOTS - 1))
      else $error("argument index out of range");

   // a report can only complete inside a CSI sequence
   a_emit_in_csi: assert property (@(posedge clock) disable iff (reset)
      emit |-> in_csi_ff && !in_escape_ff)
      else $error("report outside CSI");

endmodule

// ----- design/csirp_report.sv -----
// csirp_report: forms rows and columns of a matched report.
// Bounds: end - start + 1; cursor: position as given. Combinational.
// Depends on csirp_pkg.
`timescale 1ns / 1ps

module csirp_report #(
   parameter int ARG_SLOTS = csirp_pkg::ARG_SLOTS_DEF,
   parameter int ARG_BITS  = csirp_pkg::ARG_BITS_DEF
) (
   input  csirp_pkg::csirp_step_type                  step,
   input  logic signed [ARG_BITS-1:0]                 arg_eff [ARG_SLOTS],
   output logic signed [csirp_pkg::OUT_BITS-1:0]      rows,
   output logic signed [csirp_pkg::OUT_BITS-1:0]      columns
);
   import csirp_pkg::*;

   localparam int W = (ARG_BITS + 2 > OUT_BITS) ? ARG_BITS + 2 : OUT_BITS;

   logic signed [W-1:0] a0, a1, a2, a3, rows_w, cols_w;

   assign a0 = W'(arg_eff[0]);
   assign a1 = W'(arg_eff[1]);
   assign a2 = W'(arg_eff[2]);
   assign a3 = W'(arg_eff[3]);

   // extents for bounds, raw position for cursor
   always_comb begin
      if (step.bounds) begin
         rows_w = a2 - a0 + W'(1);
         cols_w = a3 - a1 + W'(1);
      end else begin
         rows_w = a0;
         cols_w = a1;
      end
   end

   assign rows    = rows_w[OUT_BITS-1:0];
   assign columns = cols_w[OUT_BITS-1:0];

endmodule

// ----- design/csi_report_parser_top.sv -----
// csi_report_parser_top: CSI report parser, one received byte per item.
// An accepted item passes the input register, then the result register, before its result is valid.
// Throughput: one item per cycle unless a report waits on a stalled output; the per-byte state update is combinational.
// An item with no result proceeds even while a result waits in the output register.
// Reset (synchronous, active high): parser idle, arguments at 1, report_kind = 1 (bounds).
// Depends on csirp_pkg, csirp_core, csirp_report.
`timescale 1ns / 1ps

module csi_report_parser_top #(
   parameter int ARG_SLOTS = csirp_pkg::ARG_SLOTS_DEF,
   parameter int ARG_BITS  = csirp_pkg::ARG_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_report_kind,
   // byte input
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_rx_byte,
   // report output
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [csirp_pkg::OUT_BITS-1:0] rsp_rows,
   output logic signed [csirp_pkg::OUT_BITS-1:0] rsp_columns
);
   import csirp_pkg::*;

   logic                       report_kind_ff;
   logic                       s1_valid_ff;
   logic [7:0]                 s1_byte_ff;
   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] rsp_rows_ff, rsp_columns_ff;
   logic signed [OUT_BITS-1:0] rows_in, columns_in;
   logic                       adv, req_take;
   csirp_step_type             step;
   logic signed [ARG_BITS-1:0] arg_eff [ARG_SLOTS];

   // configuration register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         report_kind_ff <= KIND_BOUNDS;
      else if (csr_valid && csr_ready)
         report_kind_ff <= csr_report_kind;
   end

   // item in the input register moves on unless it needs a busy output slot
   assign adv       = s1_valid_ff && (!step.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_take)
         s1_valid_ff <= 1'b1;
      else if (adv)
         s1_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_take)
         s1_byte_ff <= req_rx_byte;
   end

   csirp_core #(
      .ARG_SLOTS (ARG_SLOTS),
      .ARG_BITS  (ARG_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (adv),
      .rx_byte     (s1_byte_ff),
      .report_kind (report_kind_ff),
      .step        (step),
      .arg_eff     (arg_eff)
   );

   csirp_report #(
      .ARG_SLOTS (ARG_SLOTS),
      .ARG_BITS  (ARG_BITS)
   ) u_report (
      .step    (step),
      .arg_eff (arg_eff),
      .rows    (rows_in),
      .columns (columns_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv && step.emit)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv && step.emit) begin
         rsp_rows_ff    <= rows_in;
         rsp_columns_ff <= columns_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rows    = rsp_rows_ff;
   assign rsp_columns = rsp_columns_ff;

   // a new result only comes from an item that was in the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a source item");

   // a held input item keeps its byte
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && req_stall |=> s1_valid_ff && $stable(s1_byte_ff))
      else $error("input register overwritten while stalled");

   // a report never overruns a waiting result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && step.emit && rsp_valid_ff && rsp_stall |-> !adv && req_stall)
      else $error("result register overrun");

endmodule
